/* sv/ais_pkg.sv */
// ============================================================================
// ais_pkg
// Types and constants shared by the interval smoother's interfaces and modules.
// ============================================================================
package ais_pkg;

    localparam int TICK_W = 64;
    localparam int VAL_W  = 32;
    localparam int GAIN_W = 16;

    typedef logic [TICK_W-1:0] t_tick;
    typedef logic [VAL_W-1:0]  t_val;
    typedef logic [GAIN_W-1:0] t_gain;

    // Register reset: about 1e-6 ms per tick as a Q0.32 fraction.
    localparam t_val MS_PER_TICK_RESET = 32'd4295;

    // Minimum gains in Q0.16: 1/32 and 1/64.
    localparam t_gain GAIN_FLOOR_FAST = 16'd2048;
    localparam t_gain GAIN_FLOOR_SLOW = 16'd1024;

    localparam logic KIND_SAVE   = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

endpackage

/* sv/ais_if.sv */
// ============================================================================
// ais_if
// Valid/ready channels of the interval smoother: input, result and register.
// ============================================================================
interface ais_in_if;
    logic             valid;
    logic             ready;
    logic             kind;
    ais_pkg::t_tick   tick_count;

    modport source (output valid, output kind, output tick_count, input ready);
    modport sink   (input valid, input kind, input tick_count, output ready);
endinterface

interface ais_out_if;
    logic             valid;
    logic             ready;
    ais_pkg::t_val    interval_ms;
    ais_pkg::t_val    smoothed_ms;
    ais_pkg::t_val    very_smoothed_ms;

    modport source (output valid, output interval_ms, output smoothed_ms,
                    output very_smoothed_ms, input ready);
    modport sink   (input valid, input interval_ms, input smoothed_ms,
                    input very_smoothed_ms, output ready);
endinterface

interface ais_cfg_if;
    logic             valid;
    logic             ready;
    ais_pkg::t_val    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/ais_mul.sv */
// ============================================================================
// ais_mul
// Shared 32 x 32 unsigned multiplier with a registered product.
// ============================================================================
module ais_mul (
    input  logic                   i_clk,
    input  ais_pkg::t_val          i_a,
    input  ais_pkg::t_val          i_b,
    output logic [2*ais_pkg::VAL_W-1:0] o_p
);
    import ais_pkg::*;

    logic [2*VAL_W-1:0] r_p;

    // The product is registered: it appears in the cycle after the operands.
    always_ff @(posedge i_clk) begin
        r_p <= {{VAL_W{1'b0}}, i_a} * {{VAL_W{1'b0}}, i_b};
    end

    assign o_p = r_p;

endmodule

/* sv/ais_div.sv */
// ============================================================================
// ais_div
// Restoring divider giving floor(num * 2^16 / den), one quotient bit a cycle.
// ============================================================================
module ais_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  ais_pkg::t_val        i_num,
    input  logic [ais_pkg::VAL_W:0] i_den,
    output logic                 o_done,
    output ais_pkg::t_gain       o_quot
);
    import ais_pkg::*;

    logic [VAL_W:0]         r_rem;
    logic [VAL_W:0]         r_den;
    t_gain                  r_quot;
    logic [3:0]             r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [VAL_W+1:0]       shifted;
    logic [VAL_W+1:0]       trial;
    logic                   fits;

    // The numerator is below the divisor, so sixteen steps give the whole quotient.
    assign shifted = {r_rem, 1'b0};
    assign trial   = shifted - {1'b0, r_den};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd15;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? trial[VAL_W:0] : shifted[VAL_W:0];
            r_quot <= {r_quot[GAIN_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* sv/adaptive_interval_smoother_top.sv */
// ============================================================================
// adaptive_interval_smoother_top
// Frame interval measurement with two adaptive exponential averages.
// ============================================================================
// Sequence: a save beat goes straight to the output state. An update beat
// runs through the 16-step divider and four passes through the shared
// multiplier, then waits in the output state for a free output register.
// Throughput: one beat at a time; the next beat is taken once the previous one
// has been placed in the output register.
// Reset clears the start time, the interval and both averages, and loads the
// scale register with its default.
module adaptive_interval_smoother_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ais_in_if.sink       i_in,
    ais_out_if.source    o_out,
    ais_cfg_if.sink      i_cfg
);
    import ais_pkg::*;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MHI  = 4'd1;
    localparam logic [3:0] ST_MLO  = 4'd2;
    localparam logic [3:0] ST_CONV = 4'd3;
    localparam logic [3:0] ST_CMP  = 4'd4;
    localparam logic [3:0] ST_DIV  = 4'd5;
    localparam logic [3:0] ST_G    = 4'd6;
    localparam logic [3:0] ST_A1   = 4'd7;
    localparam logic [3:0] ST_A2   = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    logic [3:0]          r_state;
    logic [3:0]          n_state;

    // Architectural state.
    t_val                r_scale;
    t_tick               r_start;
    t_val                r_last;
    t_val                r_smooth;
    t_val                r_slow;

    // Working registers.
    t_tick               r_elapsed;
    logic [2*VAL_W-1:0]  r_phi;
    t_val                r_d;
    t_val                r_diff;
    t_gain               r_f;

    // Output register.
    logic                r_ovalid;
    t_val                r_o_int;
    t_val                r_o_smooth;
    t_val                r_o_slow;

    // Arithmetic units.
    t_val                mul_a;
    t_val                mul_b;
    logic [2*VAL_W-1:0]  mul_p;
    logic                div_start;
    logic                div_done;
    t_gain               div_quot;

    logic                in_acc;
    logic                out_free;
    logic [48:0]         conv_sum;
    t_val                conv_d;
    logic                d_ge_s;
    t_val                diff_s;
    t_val                max_ds;
    logic                d_ge_slow;
    t_val                diff_slow;
    t_gain               g_fast;
    t_gain               g_slow;
    t_val                step;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_ovalid || o_out.ready;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    // Interval: elapsed * scale / 2^16 from the two 32-bit halves, saturated.
    // The high partial product must fit in 16 bits, and the sum in 32 bits.
    assign conv_sum = {17'd0, r_phi[15:0], 16'd0} + {1'b0, mul_p[2*VAL_W-1:16]};
    assign conv_d   = ((r_phi[2*VAL_W-1:16] != '0) || (conv_sum[48:32] != '0))
                      ? '1 : conv_sum[31:0];

    // Gain inputs: distance from the interval to the fast average and the larger
    // of the two. The divisor adds one LSB so it is never zero.
    assign d_ge_s    = r_d >= r_smooth;
    assign diff_s    = d_ge_s ? (r_d - r_smooth) : (r_smooth - r_d);
    assign max_ds    = d_ge_s ? r_d : r_smooth;
    assign d_ge_slow = r_d >= r_slow;
    assign diff_slow = d_ge_slow ? (r_d - r_slow) : (r_slow - r_d);
    assign div_start = (r_state == ST_CMP);

    assign g_fast = (div_quot > GAIN_FLOOR_FAST) ? div_quot : GAIN_FLOOR_FAST;
    assign g_slow = (r_f > GAIN_FLOOR_SLOW) ? r_f : GAIN_FLOOR_SLOW;

    // The average step is the product scaled back from Q0.16.
    assign step = mul_p[VAL_W+15:16];

    // The multiplier is shared by four passes: the two halves of the elapsed
    // count, then the fast and slow average steps.
    always_comb begin
        mul_a = r_elapsed[VAL_W-1:0];
        mul_b = r_scale;
        case (r_state)
            ST_MHI: begin
                mul_a = r_elapsed[2*VAL_W-1:VAL_W];
                mul_b = r_scale;
            end
            ST_MLO: begin
                mul_a = r_elapsed[VAL_W-1:0];
                mul_b = r_scale;
            end
            ST_G: begin
                mul_a = r_diff;
                mul_b = {{(VAL_W-GAIN_W){1'b0}}, g_fast};
            end
            ST_A1: begin
                mul_a = diff_slow;
                mul_b = {{(VAL_W-GAIN_W){1'b0}}, g_slow};
            end
            default: begin
                mul_a = r_elapsed[VAL_W-1:0];
                mul_b = r_scale;
            end
        endcase
    end

    ais_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    ais_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (diff_s),
        .i_den   ({1'b0, max_ds} + {{VAL_W{1'b0}}, 1'b1}),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in.kind == KIND_UPDATE) ? ST_MHI : ST_OUT;
                end
            end
            ST_MHI:  n_state = ST_MLO;
            ST_MLO:  n_state = ST_CONV;
            ST_CONV: n_state = ST_CMP;
            ST_CMP:  n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_G;
                end
            end
            ST_G:    n_state = ST_A1;
            ST_A1:   n_state = ST_A2;
            ST_A2:   n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state, the scale register and the architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_scale  <= MS_PER_TICK_RESET;
            r_start  <= '0;
            r_last   <= '0;
            r_smooth <= '0;
            r_slow   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_scale <= i_cfg.data;
            end
            if (in_acc && (i_in.kind == KIND_SAVE)) begin
                r_start <= i_in.tick_count;
            end
            if (r_state == ST_CONV) begin
                r_last <= conv_d;
            end
            if (r_state == ST_A1) begin
                r_smooth <= (r_d >= r_smooth) ? (r_smooth + step) : (r_smooth - step);
            end
            if (r_state == ST_A2) begin
                r_slow <= d_ge_slow ? (r_slow + step) : (r_slow - step);
            end
            if (r_state == ST_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Working and output payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_elapsed <= i_in.tick_count - r_start;
        end
        if (r_state == ST_MLO) begin
            r_phi <= mul_p;
        end
        if (r_state == ST_CONV) begin
            r_d <= conv_d;
        end
        if (r_state == ST_CMP) begin
            r_diff <= diff_s;
        end
        if (r_state == ST_G) begin
            r_f <= div_quot;
        end
        if (r_state == ST_OUT && out_free) begin
            r_o_int    <= r_last;
            r_o_smooth <= r_smooth;
            r_o_slow   <= r_slow;
        end
    end

    assign o_out.valid            = r_ovalid;
    assign o_out.interval_ms      = r_o_int;
    assign o_out.smoothed_ms      = r_o_smooth;
    assign o_out.very_smoothed_ms = r_o_slow;

    // A save beat records its tick count as the new start time.
    a_save_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.kind == KIND_SAVE)) |=> (r_start == $past(i_in.tick_count)))
        else $error("start time not captured on a save beat");

    // A new result is only ever loaded from the output state.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == ST_OUT))
        else $error("result loaded outside the output state");

    // The slow average moves towards the interval and never overshoots it.
    a_slow_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_A2) |=>
            (($past(r_d) >= $past(r_slow)) ?
                ((r_slow >= $past(r_slow)) && (r_slow <= $past(r_d))) :
                ((r_slow <= $past(r_slow)) && (r_slow >= $past(r_d)))))
        else $error("slow average left the interval between average and target");

    // The input is never taken while the sequencer is dividing.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !in_acc)
        else $error("input accepted during division");

endmodule

/* bench/testbench.sv */
// ============================================================================
// testbench
// Self-checking bench for the adaptive interval smoother. A scripted opening
// covers the edge cases. It is followed by phases of random frame traffic,
// each under its own tick scale. Every result beat is compared field by field
// with a bit-exact fixed-point predictor kept in step with the accepted beats,
// or with the value typed in for its scripted row.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ais_pkg::*;

    // Run shape. The watchdog limit sits far above the slowest legal run: about
    // 930 beats, plus the long result hold.
    localparam int          PHASES          = 6;
    localparam int          ITEMS_PER_PHASE = 150;
    localparam int          HOLD_PHASE      = 2;
    localparam int          LONG_HOLD       = 300;
    localparam int          TAIL_CYCLES     = 60;
    localparam int unsigned CYCLE_LIMIT     = 400000;

    // One result beat, in port order.
    typedef struct packed {
        t_val interval_ms;
        t_val smoothed_ms;
        t_val very_smoothed_ms;
    } frame_times_t;

    // A typed-in expectation that travels with a scripted beat.
    typedef struct packed {
        logic         fixed;
        frame_times_t value;
    } pin_t;

    typedef enum logic {ROW_BEAT, ROW_SCALE} row_op_t;

    typedef struct packed {
        row_op_t      op;
        logic         kind;
        t_tick        ticks;
        t_val         scale;
        logic         pinned;
        frame_times_t want;
    } script_row_t;

    localparam int SCRIPT_LEN = 25;

    // Scripted opening. Only the first two rows are typed in: straight after
    // reset everything is zero, so both an early update and a save must return
    // zeros. Every other row is checked against the predictor.
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // An update before any save measures from tick zero.
        '{ROW_BEAT,  KIND_UPDATE, 64'd0,                  32'd0, 1'b1, '{32'd0, 32'd0, 32'd0}},
        '{ROW_BEAT,  KIND_SAVE,   64'd0,                  32'd0, 1'b1, '{32'd0, 32'd0, 32'd0}},
        '{ROW_BEAT,  KIND_UPDATE, 64'd16_666_667,         32'd0, 1'b0, '0},
        // A save hands back the unchanged interval and averages.
        '{ROW_BEAT,  KIND_SAVE,   64'd16_666_667,         32'd0, 1'b0, '0},
        '{ROW_BEAT,  KIND_UPDATE, 64'd33_333_334,         32'd0, 1'b0, '0},
        // A sudden long frame drives the adaptive gain up.
        '{ROW_BEAT,  KIND_SAVE,   64'd40_000_000,         32'd0, 1'b0, '0},
        '{ROW_BEAT,  KIND_UPDATE, 64'd140_000_000,        32'd0, 1'b0, '0},
        // The counter wraps between the save and the update.
        '{ROW_BEAT,  KIND_SAVE,   64'hFFFF_FFFF_FFFF_FF00, 32'd0, 1'b0, '0},
        '{ROW_BEAT,  KIND_UPDATE, 64'h0000_0000_00FF_FF00, 32'd0, 1'b0, '0},
        // A count below the start wraps to a huge span and saturates.
        '{ROW_BEAT,  KIND_SAVE,   64'd5000,               32'd0, 1'b0, '0},
        '{ROW_BEAT,  KIND_UPDATE, 64'd4000,               32'd0, 1'b0, '0},
        '{ROW_BEAT,  KIND_SAVE,   64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0, '0},
        '{ROW_BEAT,  KIND_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0, '0},
        // A zero scale turns every span into a zero interval.
        '{ROW_SCALE, KIND_SAVE,   64'd0,                  32'd0, 1'b0, '0},
        '{ROW_BEAT,  KIND_UPDATE, 64'h1234_5678_9ABC_DEF0, 32'd0, 1'b0, '0},
        '{ROW_BEAT,  KIND_SAVE,   64'd0,                  32'd0, 1'b0, '0},
        '{ROW_BEAT,  KIND_UPDATE, 64'h0000_FFFF_FFFF_FFFF, 32'd0, 1'b0, '0},
        // Full scale. Spans of 0x10000 ticks and 0x10001 ticks fall on either
        // side of the saturation point.
        '{ROW_SCALE, KIND_SAVE,   64'd0,                  32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_BEAT,  KIND_SAVE,   64'd0,                  32'd0, 1'b0, '0},
        '{ROW_BEAT,  KIND_UPDATE, 64'd1,                  32'd0, 1'b0, '0},
        '{ROW_BEAT,  KIND_UPDATE, 64'h0000_0000_0001_0000, 32'd0, 1'b0, '0},
        '{ROW_BEAT,  KIND_UPDATE, 64'h0000_0000_0001_0001, 32'd0, 1'b0, '0},
        // Back to the default scale, with the top tick bit set.
        '{ROW_SCALE, KIND_SAVE,   64'd0,                  MS_PER_TICK_RESET, 1'b0, '0},
        '{ROW_BEAT,  KIND_SAVE,   64'h8000_0000_0000_0000, 32'd0, 1'b0, '0},
        '{ROW_BEAT,  KIND_UPDATE, 64'h8000_0000_0100_0000, 32'd0, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    ais_in_if  in_ch ();
    ais_out_if out_ch ();
    ais_cfg_if cfg_ch ();

    adaptive_interval_smoother_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------------
    // Predictor state. It is advanced only when the block accepts a beat or a
    // scale write, so it always mirrors what the block should hold at that point.
    // ------------------------------------------------------------------------
    t_val  tick_scale   = MS_PER_TICK_RESET;
    t_tick anchor_ticks = '0;
    t_val  latest_ms    = '0;
    t_val  quick_mean   = '0;
    t_val  steady_mean  = '0;

    frame_times_t frames_due [$];
    pin_t         script_pins [$];

    int mismatches     = 0;
    int results_seen   = 0;
    int saves_seen     = 0;
    int updates_seen   = 0;
    int saturated_seen = 0;
    int scale_writes   = 0;

    // Shared between the stimulus process and the result sink.
    bit idle_on      = 1'b1;
    bit hold_results = 1'b0;

    // The whole 96-bit product of span and scale is formed. Anything at or
    // above bit 48 no longer fits in Q16.16, so the interval saturates.
    function automatic t_val span_to_ms(t_tick span, t_val scale);
        logic [95:0] product;
        product = {32'd0, span} * {64'd0, scale};
        if (|product[95:48])
            return '1;
        return product[47:16];
    endfunction

    // The relative change |d - s| / (max(d, s) + 1 LSB) in Q0.16. It stays
    // below one, so it always fits in sixteen bits.
    function automatic t_gain change_ratio(t_val fresh, t_val mean);
        logic [63:0] gap;
        logic [63:0] peak;
        logic [63:0] ratio;
        gap   = (fresh >= mean) ? 64'(fresh - mean) : 64'(mean - fresh);
        peak  = (fresh >= mean) ? 64'(fresh) : 64'(mean);
        ratio = (gap << 16) / (peak + 64'd1);
        return ratio[15:0];
    endfunction

    // Moves a mean towards the new interval. The step is truncated towards
    // zero, so the mean never passes the target.
    function automatic t_val pull_towards(t_val mean, t_val target, t_gain gain);
        logic [47:0] step;
        if (target >= mean) begin
            step = (48'(target - mean) * 48'(gain)) >> 16;
            return mean + step[31:0];
        end
        step = (48'(mean - target) * 48'(gain)) >> 16;
        return mean - step[31:0];
    endfunction

    function automatic frame_times_t smooth_frame(logic kind, t_tick ticks);
        t_val  fresh;
        t_gain ratio;
        t_gain quick_gain;
        t_gain steady_gain;
        if (kind == KIND_SAVE) begin
            anchor_ticks = ticks;
        end else begin
            fresh       = span_to_ms(ticks - anchor_ticks, tick_scale);
            // Both gains come from the distance to the faster mean, taken
            // before either mean moves.
            ratio       = change_ratio(fresh, quick_mean);
            quick_gain  = (ratio > GAIN_FLOOR_FAST) ? ratio : GAIN_FLOOR_FAST;
            steady_gain = (ratio > GAIN_FLOOR_SLOW) ? ratio : GAIN_FLOOR_SLOW;
            latest_ms   = fresh;
            quick_mean  = pull_towards(quick_mean, fresh, quick_gain);
            steady_mean = pull_towards(steady_mean, fresh, steady_gain);
        end
        return '{latest_ms, quick_mean, steady_mean};
    endfunction

    function automatic int field_slip(string field, t_val want, t_val got);
        if (got === want)
            return 0;
        $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, field, want, got);
        return 1;
    endfunction

    // ------------------------------------------------------------------------
    // Beat monitor. Everything is sampled on the rising edge. The result side
    // is checked before the input side, so that a result can never be matched
    // against an expectation pushed at the same edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        frame_times_t got;
        frame_times_t want;
        frame_times_t forecast;
        pin_t         pin;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                tick_scale = cfg_ch.data;
                scale_writes++;
            end

            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.interval_ms, out_ch.smoothed_ms, out_ch.very_smoothed_ms};
                results_seen++;
                if (frames_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected: 0x%08h 0x%08h 0x%08h",
                             $time, got.interval_ms, got.smoothed_ms, got.very_smoothed_ms);
                end else begin
                    want = frames_due.pop_front();
                    mismatches += field_slip("interval_ms", want.interval_ms,
                                             got.interval_ms);
                    mismatches += field_slip("smoothed_ms", want.smoothed_ms,
                                             got.smoothed_ms);
                    mismatches += field_slip("very_smoothed_ms", want.very_smoothed_ms,
                                             got.very_smoothed_ms);
                end
            end

            if (in_ch.valid && in_ch.ready) begin
                forecast = smooth_frame(in_ch.kind, in_ch.tick_count);
                pin      = script_pins.pop_front();
                // A typed-in row is checked against its own value. The
                // predictor still steps, so that later rows stay in line.
                frames_due.push_back(pin.fixed ? pin.value : forecast);
                if (in_ch.kind == KIND_SAVE) begin
                    saves_seen++;
                end else begin
                    updates_seen++;
                    if (forecast.interval_ms == '1)
                        saturated_seen++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result sink. Before a beat it may draw a short stall. Once in the run it
    // is asked to hold ready low for a long stretch. The sender keeps offering
    // beats meanwhile, so the block fills and must push back on its input.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned gap;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_results) begin
                hold_results = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            gap = idle_on ? $urandom_range(0, 4) : 0;
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Watchdog expired after %0d cycles with %0d results still due.",
                 cycles, frames_due.size());
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. Each one is entered and left on a falling edge. Valid
    // is left high after a beat, so that back-to-back beats keep it high
    // without a glitch. Whoever stops sending lowers it.
    // ------------------------------------------------------------------------
    task automatic offer_beat(input logic kind, input t_tick ticks,
                              input logic pinned = 1'b0, input frame_times_t want = '0);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        script_pins.push_back('{pinned, want});
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.tick_count <= ticks;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        @(negedge i_clk);
    endtask

    // Stops offering and waits for every outstanding result. Each beat yields
    // exactly one result, so an empty queue means the block is idle.
    task automatic drain_pipeline();
        in_ch.valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_scale(input t_val value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Frame spans sit mostly near the nominal frame, with some jitter. A few
    // are hitches several frames long, and a few are spans of any width.
    function automatic t_tick frame_span(t_tick nominal);
        t_tick wobble;
        wobble = nominal >> $urandom_range(2, 12);
        case ($urandom_range(0, 9))
            0:          return {$urandom, $urandom} >> $urandom_range(0, 63);
            1:          return nominal << $urandom_range(1, 3);
            2, 3, 4, 5: return nominal + wobble;
            default:    return nominal - wobble;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_val        phase_scale;
        t_tick       clock_now;
        t_tick       frame_ticks;
        int          sent;
        int          next_flip;
        int unsigned pick;

        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.kind       = KIND_SAVE;
        in_ch.tick_count = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The scripted opening. Scale changes wait until the block is idle.
        foreach (SCRIPT[row]) begin
            if (SCRIPT[row].op == ROW_SCALE) begin
                drain_pipeline();
                load_scale(SCRIPT[row].scale);
            end else begin
                offer_beat(SCRIPT[row].kind, SCRIPT[row].ticks,
                           SCRIPT[row].pinned, SCRIPT[row].want);
            end
        end

        // Random phases. Each phase starts from an idle block and loads a scale.
        // The nominal frame is then chosen so that intervals land well inside
        // the Q16.16 range for that scale. Hitches and wide spans still reach
        // saturation now and then.
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_pipeline();
            case (phase)
                0:       phase_scale = MS_PER_TICK_RESET;
                1:       phase_scale = $urandom;
                2:       phase_scale = 32'd1 << $urandom_range(0, 31);
                3:       phase_scale = '1;
                4:       phase_scale = $urandom_range(1, 65535);
                default: phase_scale = $urandom;
            endcase
            load_scale(phase_scale);
            frame_ticks = ((64'd1 << $urandom_range(20, 46)) / (64'(phase_scale) + 64'd1))
                          + 64'd1;
            clock_now   = {$urandom, $urandom};
            if (phase == HOLD_PHASE)
                hold_results = 1'b1;

            sent      = 0;
            next_flip = 0;
            while (sent < ITEMS_PER_PHASE) begin
                // Now and then a stretch runs with no idling on either side.
                if (sent >= next_flip) begin
                    idle_on   = ($urandom_range(0, 3) != 0);
                    next_flip = sent + 40;
                end
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    // The usual frame: mark the start, then measure.
                    offer_beat(KIND_SAVE, clock_now);
                    clock_now += frame_span(frame_ticks);
                    offer_beat(KIND_UPDATE, clock_now);
                    sent += 2;
                end else if (pick < 75) begin
                    // A measurement without a fresh start, so the span grows.
                    clock_now += frame_span(frame_ticks);
                    offer_beat(KIND_UPDATE, clock_now);
                    sent += 1;
                end else if (pick < 85) begin
                    // A frame that straddles the counter wrap.
                    clock_now = '1 - (frame_ticks >> 1);
                    offer_beat(KIND_SAVE, clock_now);
                    clock_now += frame_span(frame_ticks);
                    offer_beat(KIND_UPDATE, clock_now);
                    sent += 2;
                end else begin
                    // Noise: any kind at any count.
                    offer_beat(1'($urandom_range(0, 1)), {$urandom, $urandom});
                    sent += 1;
                end
            end
        end

        drain_pipeline();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Covered %0d saves and %0d updates (%0d saturated) under %0d scale writes.",
                 saves_seen, updates_seen, saturated_seen, scale_writes);
        $display("Checked %0d result beats; %0d field mismatches.", results_seen, mismatches);
        if (mismatches == 0 && frames_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
